FILE: hw/rtl/htle_pkg.sv
package htle_pkg;

    localparam int TITLE_LEN = 64;
    localparam int CNT_W     = $clog2(TITLE_LEN);

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TITLE_LEN - 1);
    localparam logic [CNT_W-1:0] DOT_FROM = CNT_W'(TITLE_LEN - 4);

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CASE_GAP = 8'h20;

    localparam logic [1:0] KIND_TITLE   = 2'd0;
    localparam logic [1:0] KIND_URL     = 2'd1;
    localparam logic [1:0] KIND_URL_END = 2'd2;
    localparam logic [1:0] KIND_DONE    = 2'd3;

    typedef enum logic [2:0] {
        PH_FIND_TITLE,
        PH_SKIP_GT,
        PH_TITLE,
        PH_FIND_A,
        PH_FIND_HREF,
        PH_QUOTE,
        PH_URL_FIRST,
        PH_URL
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_STAT
    } emit_state_t;

    typedef enum logic [1:0] {
        KW_TITLE,
        KW_ANCHOR,
        KW_HREF
    } kw_t;

    typedef struct packed {
        logic             done;
        logic [2:0]       pos;
    } kw_res_t;

    typedef struct packed {
        logic             run_start;
        logic             run_cut;
        logic [CNT_W-1:0] run_count;
        logic             direct_valid;
        logic [1:0]       direct_kind;
        logic [7:0]       direct_byte;
        logic             status_valid;
        logic             status;
    } htle_event_t;

    function automatic logic letter_hit(logic [7:0] k, logic [7:0] b);
        logic [7:0] up;
        begin
            up = (k >= CH_A && k <= CH_LOW_Z) ? (k - CASE_GAP) : k;
            return (b == k) || (b == up);
        end
    endfunction

    function automatic logic [2:0] kw_len(kw_t sel);
        logic [2:0] n;
        begin
            case (sel)
                KW_TITLE:  n = 3'd6;
                KW_ANCHOR: n = 3'd3;
                KW_HREF:   n = 3'd5;
                default:   n = 3'd3;
            endcase
            return n;
        end
    endfunction

    function automatic logic [7:0] kw_char(kw_t sel, logic [2:0] idx);
        logic [7:0] c;
        begin
            c = 8'h00;
            case (sel)
                KW_TITLE:
                begin
                    case (idx)
                        3'd0:    c = CH_LT;
                        3'd1:    c = CH_T;
                        3'd2:    c = CH_I;
                        3'd3:    c = CH_T;
                        3'd4:    c = CH_L;
                        3'd5:    c = CH_E;
                        default: c = 8'h00;
                    endcase
                end
                KW_ANCHOR:
                begin
                    case (idx)
                        3'd0:    c = CH_LT;
                        3'd1:    c = CH_A;
                        3'd2:    c = CH_SPACE;
                        default: c = 8'h00;
                    endcase
                end
                KW_HREF:
                begin
                    case (idx)
                        3'd0:    c = CH_H;
                        3'd1:    c = CH_R;
                        3'd2:    c = CH_E;
                        3'd3:    c = CH_F;
                        3'd4:    c = CH_EQ;
                        default: c = 8'h00;
                    endcase
                end
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

    function automatic kw_res_t kw_step(kw_t sel, logic [2:0] pos, logic [7:0] b);
        logic [2:0] len;
        logic [2:0] p;
        kw_res_t    r;
        begin
            len = kw_len(sel);
            p   = (pos < len) ? pos : 3'd0;
            if (letter_hit(kw_char(sel, p), b))
            begin
                p = p + 3'd1;
            end
            else
            begin
                p = letter_hit(kw_char(sel, 3'd0), b) ? 3'd1 : 3'd0;
            end
            r.done = (p >= len);
            r.pos  = r.done ? 3'd0 : p;
            return r;
        end
    endfunction

endpackage

FILE: hw/rtl/html_title_and_link_extractor.sv
// A url result, or a status on its own, is registered and shows in the cycle after
// the causing transfer; the first byte of a title run passes the run state, the title
// memory read register and the output register. Throughput: one byte per cycle while the
// output keeps up; a title run (one memory read per cycle while the output keeps up) and a
// status that follows a url result or a run each hold the input in their own state.
// Reset: rst_n clears all control state at once; the title memory is not cleared.
module html_title_and_link_extractor import htle_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // in_byte
    input  logic       s_axis_tlast,   // stream_end
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // out_byte
    output logic       m_axis_tlast,   // run_last
    output logic [2:0] m_axis_tuser    // out_kind[1:0], status
);

    logic             accept;
    htle_event_t      ev;
    logic             ram_we;
    logic [CNT_W-1:0] ram_waddr;
    logic [7:0]       ram_wdata;
    logic             ram_re;
    logic [CNT_W-1:0] ram_raddr;
    logic [7:0]       ram_rdata;

    assign accept = s_axis_tvalid && s_axis_tready;

    htle_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_byte    (s_axis_tdata),
        .stream_end (s_axis_tlast),
        .ev         (ev),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata)
    );

    htle_ram #(
        .WIDTH (8),
        .DEPTH (TITLE_LEN)
    ) u_title_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    htle_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .ev            (ev),
        .in_ready      (s_axis_tready),
        .ram_re        (ram_re),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

`ifndef SYNTHESIS
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("title memory written during a run readout");

    a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        accept && ev.run_start && (ev.run_count != '0) |=> !s_axis_tready)
        else $error("input taken while a title run is pending");

    a_last_only_title: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[1:0] != KIND_TITLE) |-> !m_axis_tlast)
        else $error("run end flag on a non-title transfer");

    a_status_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[1:0] != KIND_DONE) |-> !m_axis_tuser[2])
        else $error("status flag on a non-status transfer");
`endif

endmodule

FILE: hw/rtl/htle_ram.sv
module htle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/htle_scan.sv
module htle_scan import htle_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       in_byte,
    input  logic             stream_end,
    output htle_event_t      ev,
    output logic             ram_we,
    output logic [CNT_W-1:0] ram_waddr,
    output logic [7:0]       ram_wdata
);

    phase_t           phase_reg, phase_next, phase_step;
    logic [2:0]       match_reg, match_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pend_reg, pend_next;
    logic [7:0]       quote_reg, quote_next;

    kw_t              kw_sel;
    kw_res_t          kw_res;
    logic [CNT_W-1:0] c1;
    logic             c_full;
    logic             url_stop;

    logic             t_we;
    logic [CNT_W-1:0] t_waddr;
    logic [7:0]       t_wdata;
    logic [CNT_W-1:0] t_count_n;
    logic             t_pend_n;
    logic             t_finish;
    logic             t_cut;

    assign kw_sel   = (phase_reg == PH_FIND_TITLE) ? KW_TITLE :
                      (phase_reg == PH_FIND_HREF)  ? KW_HREF  : KW_ANCHOR;
    assign kw_res   = kw_step(kw_sel, match_reg, in_byte);
    assign c1       = count_reg + CNT_W'(1);
    assign c_full   = (count_reg == CNT_FULL);
    assign url_stop = (in_byte == quote_reg) || (in_byte == CH_SPACE) || (in_byte == CH_LT);

    // Title store: a '<' is written ahead at the next slot and counted only once
    // the following byte shows it does not open a closing tag.
    always_comb
    begin
        t_we      = 1'b0;
        t_waddr   = count_reg;
        t_wdata   = in_byte;
        t_count_n = count_reg;
        t_pend_n  = pend_reg;
        t_finish  = 1'b0;
        t_cut     = 1'b0;
        if (!pend_reg)
        begin
            if (in_byte == CH_LT)
            begin
                t_we     = 1'b1;
                t_wdata  = CH_LT;
                t_pend_n = 1'b1;
            end
            else if (!c_full)
            begin
                t_we      = 1'b1;
                t_count_n = c1;
            end
            else
            begin
                t_finish = 1'b1;
                t_cut    = 1'b1;
            end
        end
        else
        begin
            t_pend_n = 1'b0;
            if (in_byte == CH_SLASH)
            begin
                t_finish = 1'b1;
            end
            else if (c_full)
            begin
                t_finish = 1'b1;
                t_cut    = 1'b1;
            end
            else if (in_byte == CH_LT)
            begin
                t_we      = 1'b1;
                t_waddr   = c1;
                t_wdata   = CH_LT;
                t_count_n = c1;
                t_pend_n  = 1'b1;
            end
            else if (c1 != CNT_FULL)
            begin
                t_we      = 1'b1;
                t_waddr   = c1;
                t_count_n = c1 + CNT_W'(1);
            end
            else
            begin
                t_finish = 1'b1;
                t_cut    = 1'b1;
            end
        end
    end

    always_comb
    begin
        phase_step = phase_reg;
        match_next = match_reg;
        count_next = count_reg;
        pend_next  = pend_reg;
        quote_next = quote_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_FIND_TITLE:
                begin
                    match_next = kw_res.pos;
                    if (kw_res.done)
                    begin
                        phase_step = PH_SKIP_GT;
                    end
                end
                PH_SKIP_GT:
                begin
                    if (in_byte == CH_GT)
                    begin
                        phase_step = PH_TITLE;
                        count_next = '0;
                        pend_next  = 1'b0;
                    end
                end
                PH_TITLE:
                begin
                    if (t_finish)
                    begin
                        phase_step = PH_FIND_A;
                        count_next = '0;
                        pend_next  = 1'b0;
                        match_next = 3'd0;
                    end
                    else
                    begin
                        count_next = t_count_n;
                        pend_next  = t_pend_n;
                    end
                end
                PH_FIND_HREF:
                begin
                    match_next = kw_res.pos;
                    if (kw_res.done)
                    begin
                        phase_step = PH_QUOTE;
                    end
                end
                PH_QUOTE:
                begin
                    quote_next = in_byte;
                    phase_step = PH_URL_FIRST;
                end
                PH_URL_FIRST:
                begin
                    match_next = 3'd0;
                    if (in_byte == CH_H && quote_reg != CH_H)
                    begin
                        phase_step = PH_URL;
                    end
                    else
                    begin
                        phase_step = PH_FIND_A;
                    end
                end
                PH_URL:
                begin
                    if (url_stop)
                    begin
                        phase_step = PH_FIND_A;
                        match_next = 3'd0;
                    end
                end
                default:
                begin
                    match_next = kw_res.pos;
                    phase_step = kw_res.done ? PH_FIND_HREF : PH_FIND_A;
                end
            endcase
        end
        phase_next = phase_step;
        if (accept && stream_end)
        begin
            phase_next = PH_FIND_TITLE;
            match_next = 3'd0;
            count_next = '0;
            pend_next  = 1'b0;
            quote_next = 8'h00;
        end
    end

    always_comb
    begin
        ev        = '0;
        ram_we    = 1'b0;
        ram_waddr = t_waddr;
        ram_wdata = t_wdata;
        if (accept)
        begin
            case (phase_reg)
                PH_TITLE:
                begin
                    ram_we = t_we;
                    if (t_finish)
                    begin
                        ev.run_start = 1'b1;
                        ev.run_cut   = t_cut;
                        ev.run_count = t_cut ? CNT_FULL : count_reg;
                    end
                end
                PH_URL_FIRST:
                begin
                    if (in_byte == CH_H)
                    begin
                        ev.direct_valid = 1'b1;
                        if (quote_reg == CH_H)
                        begin
                            ev.direct_kind = KIND_URL_END;
                        end
                        else
                        begin
                            ev.direct_kind = KIND_URL;
                            ev.direct_byte = in_byte;
                        end
                    end
                end
                PH_URL:
                begin
                    ev.direct_valid = 1'b1;
                    if (url_stop)
                    begin
                        ev.direct_kind = KIND_URL_END;
                    end
                    else
                    begin
                        ev.direct_kind = KIND_URL;
                        ev.direct_byte = in_byte;
                    end
                end
                default:
                begin
                    ev.direct_valid = 1'b0;
                end
            endcase
            if (stream_end)
            begin
                ev.status_valid = 1'b1;
                ev.status       = !(phase_step == PH_FIND_TITLE || phase_step == PH_FIND_A);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIND_TITLE;
            match_reg <= 3'd0;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            quote_reg <= 8'h00;
        end
        else
        begin
            phase_reg <= phase_next;
            match_reg <= match_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            quote_reg <= quote_next;
        end
    end

endmodule

FILE: hw/rtl/htle_emit.sv
module htle_emit import htle_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  htle_event_t      ev,
    output logic             in_ready,
    output logic             ram_re,
    output logic [CNT_W-1:0] ram_raddr,
    input  logic [7:0]       ram_rdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // out_byte
    output logic             m_axis_tlast,  // run_last
    output logic [2:0]       m_axis_tuser   // out_kind[1:0], status
);

    emit_state_t      state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             cut_reg, cut_next;
    logic             spend_reg, spend_next;
    logic             sval_reg, sval_next;
    logic             rpend_reg, rpend_next;
    logic             rlast_reg, rlast_next;
    logic             rdot_reg, rdot_next;
    logic             ov_reg, ov_next;
    logic [1:0]       okind_reg, okind_next;
    logic [7:0]       obyte_reg, obyte_next;
    logic             olast_reg, olast_next;
    logic             ostat_reg, ostat_next;

    logic             out_free;
    logic             rd_load;
    logic             rd_issue;
    logic             run_done;
    logic             run_go;

    assign out_free = !ov_reg || m_axis_tready;
    assign rd_load  = (state_reg == ST_RUN) && rpend_reg && out_free;
    assign rd_issue = (state_reg == ST_RUN) && (idx_reg < cnt_reg) && (!rpend_reg || rd_load);
    assign run_done = (state_reg == ST_RUN) && (idx_reg == cnt_reg) && (!rpend_reg || rd_load);
    assign run_go   = ev.run_start && (ev.run_count != '0);
    assign in_ready = (state_reg == ST_IDLE) && out_free;

    assign ram_re    = rd_issue;
    assign ram_raddr = idx_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (run_go)
                    begin
                        state_next = ST_RUN;
                    end
                    else if (ev.direct_valid && ev.status_valid)
                    begin
                        state_next = ST_STAT;
                    end
                end
            end
            ST_RUN:
            begin
                if (run_done)
                begin
                    state_next = spend_reg ? ST_STAT : ST_IDLE;
                end
            end
            ST_STAT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        cut_next   = cut_reg;
        spend_next = spend_reg;
        sval_next  = sval_reg;
        rpend_next = rpend_reg;
        rlast_next = rlast_reg;
        rdot_next  = rdot_reg;
        ov_next    = ov_reg && !m_axis_tready;
        okind_next = okind_reg;
        obyte_next = obyte_reg;
        olast_next = olast_reg;
        ostat_next = ostat_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    spend_next = ev.status_valid;
                    sval_next  = ev.status;
                    if (run_go)
                    begin
                        idx_next = '0;
                        cnt_next = ev.run_count;
                        cut_next = ev.run_cut;
                    end
                    else if (ev.direct_valid)
                    begin
                        ov_next    = 1'b1;
                        okind_next = ev.direct_kind;
                        obyte_next = ev.direct_byte;
                        olast_next = 1'b0;
                        ostat_next = 1'b0;
                    end
                    else if (ev.status_valid)
                    begin
                        spend_next = 1'b0;
                        ov_next    = 1'b1;
                        okind_next = KIND_DONE;
                        obyte_next = 8'h00;
                        olast_next = 1'b0;
                        ostat_next = ev.status;
                    end
                end
            end
            ST_RUN:
            begin
                if (rd_load)
                begin
                    ov_next    = 1'b1;
                    okind_next = KIND_TITLE;
                    obyte_next = rdot_reg ? CH_DOT : ram_rdata;
                    olast_next = rlast_reg;
                    ostat_next = 1'b0;
                    rpend_next = 1'b0;
                end
                if (rd_issue)
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    rpend_next = 1'b1;
                    rlast_next = (idx_reg == cnt_reg - CNT_W'(1));
                    rdot_next  = cut_reg && (idx_reg >= DOT_FROM);
                end
            end
            ST_STAT:
            begin
                if (out_free)
                begin
                    spend_next = 1'b0;
                    ov_next    = 1'b1;
                    okind_next = KIND_DONE;
                    obyte_next = 8'h00;
                    olast_next = 1'b0;
                    ostat_next = sval_reg;
                end
            end
            default: ov_next = ov_reg && !m_axis_tready;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            cut_reg   <= 1'b0;
            spend_reg <= 1'b0;
            sval_reg  <= 1'b0;
            rpend_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            cut_reg   <= cut_next;
            spend_reg <= spend_next;
            sval_reg  <= sval_next;
            rpend_reg <= rpend_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rlast_reg <= rlast_next;
        rdot_reg  <= rdot_next;
        okind_reg <= okind_next;
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
        ostat_reg <= ostat_next;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = obyte_reg;
    assign m_axis_tlast  = olast_reg;
    assign m_axis_tuser  = {ostat_reg, okind_reg};

endmodule

FILE: test/htle_checker.sv
`timescale 1ns / 100ps

module htle_checker
    import htle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // in_byte
    input  logic       s_axis_tlast,   // stream_end
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,   // out_byte
    input  logic       m_axis_tlast,   // run_last
    input  logic [2:0] m_axis_tuser,   // out_kind[1:0], status
    output int         fail_count,
    output int         results_due
);

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       run_last;
        logic       status;
    } extract_result_t;

    localparam logic [47:0] WORD_TITLE  = "<title";
    localparam logic [47:0] WORD_ANCHOR = "<a ";
    localparam logic [47:0] WORD_HREF   = "href=";

    extract_result_t expected_results[$];

    phase_t     scan_phase = PH_FIND_TITLE;
    int         kw_pos     = 0;
    logic [7:0] title_mem[TITLE_LEN];
    int         title_len  = 0;
    logic       open_lt    = 1'b0;
    logic [7:0] url_quote  = 8'h00;

    function automatic bit same_letter(logic [7:0] k, logic [7:0] b);
        logic [7:0] upper;
        upper = (k >= CH_A && k <= CH_LOW_Z) ? (k - CASE_GAP) : k;
        return (b == k) || (b == upper);
    endfunction

    function automatic bit advance_keyword(logic [47:0] word, int len, logic [7:0] b);
        int p;
        p = (kw_pos < len) ? kw_pos : 0;
        if (same_letter(word[8*(len-1-p) +: 8], b))
        begin
            p++;
        end
        else
        begin
            p = same_letter(word[8*(len-1) +: 8], b) ? 1 : 0;
        end
        if (p >= len)
        begin
            kw_pos = 0;
            return 1'b1;
        end
        kw_pos = p;
        return 1'b0;
    endfunction

    function automatic void push_result(logic [1:0] kind, logic [7:0] data, logic rl,
                                        logic st);
        extract_result_t r;
        r.kind     = kind;
        r.data     = data;
        r.run_last = rl;
        r.status   = st;
        expected_results.push_back(r);
    endfunction

    function automatic void flush_title();
        for (int i = 0; i < title_len; i++)
        begin
            push_result(KIND_TITLE, title_mem[i], (i + 1 == title_len), 1'b0);
        end
        title_len  = 0;
        open_lt    = 1'b0;
        kw_pos     = 0;
        scan_phase = PH_FIND_A;
    endfunction

    // store one byte; cut the title at the buffer limit
    function automatic bit keep_title_byte(logic [7:0] b);
        if (title_len < TITLE_LEN - 1)
        begin
            title_mem[title_len] = b;
            title_len++;
            return 1'b0;
        end
        title_mem[title_len-3] = CH_DOT;
        title_mem[title_len-2] = CH_DOT;
        title_mem[title_len-1] = CH_DOT;
        flush_title();
        return 1'b1;
    endfunction

    function automatic void title_char(logic [7:0] b);
        if (b == CH_LT)
        begin
            open_lt = 1'b1;
        end
        else
        begin
            void'(keep_title_byte(b));
        end
    endfunction

    function automatic void clear_scan();
        scan_phase = PH_FIND_TITLE;
        kw_pos     = 0;
        title_len  = 0;
        open_lt    = 1'b0;
        url_quote  = 8'h00;
    endfunction

    function automatic void predict_byte(logic [7:0] b, logic eod);
        case (scan_phase)
            PH_FIND_TITLE:
            begin
                if (advance_keyword(WORD_TITLE, 6, b))
                begin
                    scan_phase = PH_SKIP_GT;
                end
            end
            PH_SKIP_GT:
            begin
                if (b == CH_GT)
                begin
                    scan_phase = PH_TITLE;
                    title_len  = 0;
                    open_lt    = 1'b0;
                end
            end
            PH_TITLE:
            begin
                if (open_lt)
                begin
                    open_lt = 1'b0;
                    if (b == CH_SLASH)
                    begin
                        flush_title();
                    end
                    else if (!keep_title_byte(CH_LT))
                    begin
                        title_char(b);
                    end
                end
                else
                begin
                    title_char(b);
                end
            end
            PH_FIND_HREF:
            begin
                if (advance_keyword(WORD_HREF, 5, b))
                begin
                    scan_phase = PH_QUOTE;
                end
            end
            PH_QUOTE:
            begin
                url_quote  = b;
                scan_phase = PH_URL_FIRST;
            end
            PH_URL_FIRST:
            begin
                if (b == CH_H)
                begin
                    if (b == url_quote)
                    begin
                        push_result(KIND_URL_END, 8'h00, 1'b0, 1'b0);
                        scan_phase = PH_FIND_A;
                    end
                    else
                    begin
                        push_result(KIND_URL, b, 1'b0, 1'b0);
                        scan_phase = PH_URL;
                    end
                end
                else
                begin
                    scan_phase = PH_FIND_A;
                end
                kw_pos = 0;
            end
            PH_URL:
            begin
                if (b == url_quote || b == CH_SPACE || b == CH_LT)
                begin
                    push_result(KIND_URL_END, 8'h00, 1'b0, 1'b0);
                    scan_phase = PH_FIND_A;
                    kw_pos     = 0;
                end
                else
                begin
                    push_result(KIND_URL, b, 1'b0, 1'b0);
                end
            end
            default:
            begin
                scan_phase = PH_FIND_A;
                if (advance_keyword(WORD_ANCHOR, 3, b))
                begin
                    scan_phase = PH_FIND_HREF;
                end
            end
        endcase
        if (eod)
        begin
            push_result(KIND_DONE, 8'h00, 1'b0,
                        (scan_phase == PH_FIND_TITLE || scan_phase == PH_FIND_A) ? 1'b0 : 1'b1);
            clear_scan();
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        extract_result_t want;
        extract_result_t got;
        if (!rst_n)
        begin
            clear_scan();
            expected_results.delete();
            fail_count  = 0;
            results_due = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_byte(s_axis_tdata, s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.kind     = m_axis_tuser[1:0];
                got.data     = m_axis_tdata;
                got.run_last = m_axis_tlast;
                got.status   = m_axis_tuser[2];
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result kind=%0d byte=%02h last=%0b status=%0b",
                             $time, got.kind, got.data, got.run_last, got.status);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.kind !== want.kind || got.data !== want.data
                        || got.run_last !== want.run_last || got.status !== want.status)
                    begin
                        $display("%0t: mismatch expected kind=%0d byte=%02h last=%0b status=%0b",
                                 $time, want.kind, want.data, want.run_last, want.status);
                        $display("%0t:          actual   kind=%0d byte=%02h last=%0b status=%0b",
                                 $time, got.kind, got.data, got.run_last, got.status);
                        fail_count++;
                    end
                end
            end
            results_due = expected_results.size();
        end
    end

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps

module tb;
    import htle_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_LEN     = 300;

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;
    logic [2:0] m_axis_tuser;

    int fail_count;
    int results_due;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int hold_cycles   = 0;
    int cycle_count   = 0;
    int bytes_sent    = 0;

    logic [7:0] doc_bytes[$];

    html_title_and_link_extractor i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    htle_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .results_due   (results_due)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // hold off for a long stretch when asked, else stall at random
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles--;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    function automatic logic [7:0] mixed_case(logic [7:0] c);
        if (c >= CH_A && c <= CH_LOW_Z && $urandom_range(1) == 1)
        begin
            return c - CASE_GAP;
        end
        return c;
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
        begin
            doc_bytes.push_back(s[i]);
        end
    endfunction

    function automatic void add_word(string s);
        for (int i = 0; i < s.len(); i++)
        begin
            doc_bytes.push_back(mixed_case(s[i]));
        end
    endfunction

    function automatic void add_noise(int n);
        string pool;
        pool = " <>/=aAtThHrRefl\"'.x";
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) < 3)
            begin
                doc_bytes.push_back(8'($urandom_range(255)));
            end
            else
            begin
                doc_bytes.push_back(pool[$urandom_range(pool.len() - 1)]);
            end
        end
    endfunction

    function automatic void add_link();
        string      url_pool;
        logic [7:0] quote;
        int         r;
        url_pool = "htp:/.wexmHT0";
        add_noise($urandom_range(3));
        if ($urandom_range(7) == 0)
        begin
            add_word("<a");
            return;
        end
        add_word("<a ");
        add_noise($urandom_range(2));
        if ($urandom_range(7) == 0)
        begin
            add_word("hre");
        end
        add_word("href=");
        r = $urandom_range(5);
        case (r)
            0, 1:    quote = "\"";
            2:       quote = "'";
            3:       quote = CH_H;
            default: quote = 8'($urandom_range(255));
        endcase
        doc_bytes.push_back(quote);
        doc_bytes.push_back(($urandom_range(4) == 0) ? 8'($urandom_range(255)) : CH_H);
        r = $urandom_range(6);
        for (int i = 0; i < r; i++)
        begin
            if ($urandom_range(7) == 0)
            begin
                doc_bytes.push_back(8'($urandom_range(255)));
            end
            else
            begin
                doc_bytes.push_back(url_pool[$urandom_range(url_pool.len() - 1)]);
            end
        end
        case ($urandom_range(2))
            0:       doc_bytes.push_back(quote);
            1:       doc_bytes.push_back(CH_SPACE);
            default: doc_bytes.push_back(CH_LT);
        endcase
    endfunction

    function automatic void build_doc();
        int r;
        int n;
        doc_bytes.delete();
        if ($urandom_range(11) == 0)
        begin
            add_noise($urandom_range(1, 8));
            return;
        end
        add_noise($urandom_range(4));
        if ($urandom_range(9) == 0)
        begin
            add_word("<tit");
        end
        add_word("<title");
        add_noise($urandom_range(3));
        doc_bytes.push_back(CH_GT);
        r = $urandom_range(15);
        n = (r == 0) ? $urandom_range(60, 70) : (r < 3) ? 0 : $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
        begin
            doc_bytes.push_back(($urandom_range(9) == 0) ? CH_LT : 8'($urandom_range(255)));
        end
        add_word("</title>");
        n = $urandom_range(3);
        for (int i = 0; i < n; i++)
        begin
            add_link();
        end
        add_noise($urandom_range(3));
        if ($urandom_range(4) == 0)
        begin
            n = $urandom_range(1, doc_bytes.size());
            while (doc_bytes.size() > n)
            begin
                void'(doc_bytes.pop_back());
            end
        end
    endfunction

    // entered and left at a falling edge; hold valid until the transfer
    task automatic send_byte(logic [7:0] b, logic eod);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eod;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_doc();
        for (int i = 0; i < doc_bytes.size(); i++)
        begin
            send_byte(doc_bytes[i], (i == doc_bytes.size() - 1));
        end
    endtask

    task automatic run_docs(int count);
        int goal;
        goal = bytes_sent + count;
        while (bytes_sent < goal)
        begin
            build_doc();
            send_doc();
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (results_due != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        src_idle_pct  = 11;
        sink_idle_pct = 49;
        doc_bytes.delete();
        add_text("<<TiTLe>x<y</<A hReF=hh");
        send_doc();
        doc_bytes.delete();
        doc_bytes.push_back(8'h00);
        doc_bytes.push_back(8'hFF);
        send_doc();

        hold_cycles = HOLD_LEN;
        run_docs(110);
        wait_drained();

        src_idle_pct  = 49;
        sink_idle_pct = 11;
        run_docs(110);
        wait_drained();

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_docs(110);
        wait_drained();

        if (fail_count == 0 && results_due == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
